@@ design/sink_attraction_force_unit_assert.svh @@
// Assertion macros shared by the checker of the sink attraction force unit.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef SINK_ATTRACTION_FORCE_UNIT_ASSERT_SVH
`define SINK_ATTRACTION_FORCE_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define SAFU_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("safu: same-cycle check failed");

// consequent checked in the next cycle
`define SAFU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("safu: next-cycle check failed");

`endif

@@ design/safu_pkg.sv @@
// Types, register indexes and the square-root step of the sink attraction force unit.
// No dependencies.
package safu_pkg;

	localparam logic [2:0] REG_SINK_X    = 3'd0;
	localparam logic [2:0] REG_SINK_Y    = 3'd1;
	localparam logic [2:0] REG_SINK_Z    = 3'd2;
	localparam logic [2:0] REG_PEAK      = 3'd3;
	localparam logic [2:0] REG_CRIT_DIST = 3'd4;
	localparam logic [2:0] REG_DROP      = 3'd5;

	localparam int SQ_N  = 33;	// result bits of the root
	localparam int DIV_N = 31;	// quotient bits of the falloff term
	localparam int LO_W  = 24;	// low slice of the split force multiply

	// data that rides alongside the arithmetic
	typedef struct packed {
		logic [2:0][31:0] ad;
		logic [2:0]       neg;
		logic [30:0]      vol;
	} side_t;

	typedef struct packed {
		logic [34:0] rem;
		logic [32:0] root;
	} sqrt_st_t;

	// one digit of a restoring square root
	function automatic sqrt_st_t sqrt_step(input sqrt_st_t cur, input logic [1:0] pair);
		logic [36:0] r;
		logic [36:0] tr;
		sqrt_st_t    nx;
		r  = {cur.rem, pair};
		tr = {2'b00, cur.root, 2'b01};
		if (r >= tr) begin
			nx.rem  = 35'(r - tr);
			nx.root = {cur.root[31:0], 1'b1};
		end else begin
			nx.rem  = r[34:0];
			nx.root = {cur.root[31:0], 1'b0};
		end
		return nx;
	endfunction

endpackage

@@ design/sink_attraction_force_unit.sv @@
// Sink attraction force unit: one particle in, one body force out.
// Uses safu_pkg.
//
// Usage
//   s_t* carries particles, m_t* carries forces, cfg_* writes the six
//   registers (sink point, peak force, critical distance, pressure drop).
//   The user must write the registers only while no item is in flight;
//   the block does not enforce it. Throughput is one item per clock
//   unless stalled. It has 73 register stages: 33 root stages, 31
//   divider stages for the falloff term (the three direction dividers
//   run in the first FRAC_BITS+1 of them), plus input, square, sum,
//   multiply, divider entry, subtract, volume, clamp and output stages.
//   The whole pipeline advances together; it moves whenever the output
//   register is empty or being taken, so s_tready follows m_tready while
//   a result is held. A stall freezes every stage, nothing is lost.
//   Reset clears the valid bits and sets the registers to their defaults
//   (critical distance 1.0, all else zero). cfg_ready is always high.
//   A particle on the sink, or with no positive magnitude, gives zero
//   force; components saturate to the signed 32-bit range.
module sink_attraction_force_unit
	import safu_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,	// pos_x, pos_y, pos_z, volume(31), pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,	// force_x, force_y, force_z
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int U_N  = FRAC_BITS + 1;
	localparam int F_W  = 62 - FRAC_BITS;
	localparam int FC_W = 32 + FRAC_BITS;
	localparam int HI_W = FC_W - LO_W;
	localparam int P_W  = FC_W + U_N;
	localparam int NST  = 6 + SQ_N + DIV_N + 2 + 1;	// 73 stages

	logic adv;
	logic [NST-1:0] v_q;

	logic [2:0][31:0] sink_q;
	logic [30:0] peak_q, crit_q, drop_q;

	assign cfg_ready = 1'b1;
	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;
	assign m_tvalid  = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_q <= '0;
			peak_q <= '0;
			crit_q <= 31'd65536;
			drop_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SINK_X:    sink_q[0] <= cfg_data;
				REG_SINK_Y:    sink_q[1] <= cfg_data;
				REG_SINK_Z:    sink_q[2] <= cfg_data;
				REG_PEAK:      peak_q    <= cfg_data[30:0];
				REG_CRIT_DIST: crit_q    <= cfg_data[30:0];
				REG_DROP:      drop_q    <= cfg_data[30:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NST-2:0], s_tvalid};
		end
	end

	// stage 1: difference to the sink, split into magnitude and sign
	logic [2:0][32:0] d_c;
	side_t sd_c, sd_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = {sink_q[i][31], sink_q[i]} - {s_tdata[32*i+31], s_tdata[32*i +: 32]};
			sd_c.neg[i] = d_c[i][32];
			sd_c.ad[i]  = d_c[i][32] ? 32'(~d_c[i] + 33'd1) : d_c[i][31:0];
		end
		sd_c.vol = s_tdata[126:96];
	end

	always_ff @(posedge clk) begin
		if (adv) sd_s1 <= sd_c;
	end

	// stage 2: squares
	logic [2:0][63:0] sq_s2;
	side_t sd_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) sq_s2[i] <= sd_s1.ad[i] * sd_s1.ad[i];
			sd_s2 <= sd_s1;
		end
	end

	// root pipeline, entry 0 holds the 66-bit sum
	logic [65:0] sq_op [SQ_N+1];
	sqrt_st_t    sq_st [SQ_N+1];
	side_t       sq_sd [SQ_N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_op[0] <= 66'(sq_s2[0]) + 66'(sq_s2[1]) + 66'(sq_s2[2]);
			sq_st[0] <= '0;
			sq_sd[0] <= sd_s2;
		end
	end

	for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_st[j+1] <= sqrt_step(sq_st[j], sq_op[j][65:64]);
				sq_op[j+1] <= sq_op[j] << 2;
				sq_sd[j+1] <= sq_sd[j];
			end
		end
	end

	// stage 4: length times pressure drop
	logic [32:0] len_s4;
	logic [63:0] prod_s4;
	side_t       sd_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s4  <= sq_st[SQ_N].root;
			prod_s4 <= sq_st[SQ_N].root * drop_q;
			sd_s4   <= sq_sd[SQ_N];
		end
	end

	// divider pipeline: falloff quotient and the three direction quotients
	logic [30:0] crit_e;
	logic [30:0] dv_trem [DIV_N+1];
	logic [30:0] dv_tbit [DIV_N+1];
	logic [30:0] dv_tq   [DIV_N+1];
	logic [2:0][32:0]    dv_urem [DIV_N+1];
	logic [2:0][U_N-1:0] dv_ubit [DIV_N+1];
	logic [2:0][U_N-1:0] dv_uq   [DIV_N+1];
	logic [32:0] dv_len  [DIV_N+1];
	logic        dv_kill [DIV_N+1];
	side_t       dv_sd   [DIV_N+1];

	assign crit_e = (crit_q == '0) ? 31'd1 : crit_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			// quotient of 2^31 or more can never stay below the peak force
			dv_kill[0] <= (len_s4 == '0) || (prod_s4[63:31] >= {2'b00, crit_e});
			dv_trem[0] <= prod_s4[61:31];
			dv_tbit[0] <= prod_s4[30:0];
			dv_tq[0]   <= '0;
			for (int i = 0; i < 3; i++) begin
				dv_urem[0][i] <= {2'b00, sd_s4.ad[i][31:1]};
				dv_ubit[0][i] <= U_N'(sd_s4.ad[i][0]) << FRAC_BITS;
				dv_uq[0][i]   <= '0;
			end
			dv_len[0] <= len_s4;
			dv_sd[0]  <= sd_s4;
		end
	end

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [31:0] tr;
		assign tr = {dv_trem[k], dv_tbit[k][30]};

		always_ff @(posedge clk) begin
			if (adv) begin
				if (tr >= {1'b0, crit_e}) begin
					dv_trem[k+1] <= 31'(tr - {1'b0, crit_e});
					dv_tq[k+1]   <= {dv_tq[k][29:0], 1'b1};
				end else begin
					dv_trem[k+1] <= tr[30:0];
					dv_tq[k+1]   <= {dv_tq[k][29:0], 1'b0};
				end
				dv_tbit[k+1] <= dv_tbit[k] << 1;
				dv_len[k+1]  <= dv_len[k];
				dv_kill[k+1] <= dv_kill[k];
				dv_sd[k+1]   <= dv_sd[k];
			end
		end

		if (k < U_N) begin : g_u
			logic [2:0][33:0] ur;
			always_comb begin
				for (int i = 0; i < 3; i++) ur[i] = {dv_urem[k][i], dv_ubit[k][i][U_N-1]};
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					for (int i = 0; i < 3; i++) begin
						if (ur[i] >= {1'b0, dv_len[k]}) begin
							dv_urem[k+1][i] <= 33'(ur[i] - {1'b0, dv_len[k]});
							dv_uq[k+1][i]   <= {dv_uq[k][i][U_N-2:0], 1'b1};
						end else begin
							dv_urem[k+1][i] <= ur[i][32:0];
							dv_uq[k+1][i]   <= {dv_uq[k][i][U_N-2:0], 1'b0};
						end
						dv_ubit[k+1][i] <= dv_ubit[k][i] << 1;
					end
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_urem[k+1] <= dv_urem[k];
					dv_ubit[k+1] <= dv_ubit[k];
					dv_uq[k+1]   <= dv_uq[k];
				end
			end
		end
	end

	// stage 6: magnitude per unit volume
	logic [30:0] m_s6;
	logic        kill_s6;
	logic [2:0][U_N-1:0] u_s6;
	logic [2:0]  neg_s6;
	logic [30:0] vol_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s6    <= peak_q - dv_tq[DIV_N];
			kill_s6 <= dv_kill[DIV_N] || (dv_tq[DIV_N] >= peak_q);
			u_s6    <= dv_uq[DIV_N];
			neg_s6  <= dv_sd[DIV_N].neg;
			vol_s6  <= dv_sd[DIV_N].vol;
		end
	end

	// stage 7: times volume
	logic [61:0]    mv_c;
	logic [F_W-1:0] f_s7;
	logic           kill_s7;
	logic [2:0][U_N-1:0] u_s7;
	logic [2:0]     neg_s7;

	assign mv_c = m_s6 * vol_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s7    <= mv_c[61:FRAC_BITS];
			kill_s7 <= kill_s6;
			u_s7    <= u_s6;
			neg_s7  <= neg_s6;
		end
	end

	// stage 8: clamp and split multiply; a clamped value saturates unless its direction quotient is zero
	logic [63:0] f64_c, lim_c, fc_c;
	logic [2:0][LO_W+U_N-1:0] plo_s8;
	logic [2:0][HI_W+U_N-1:0] phi_s8;
	logic        kill_s8;
	logic [2:0]  neg_s8;

	assign f64_c = 64'(f_s7);
	assign lim_c = 64'(1) << (31 + FRAC_BITS);
	assign fc_c  = (f64_c >= lim_c) ? lim_c : f64_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				plo_s8[i] <= fc_c[LO_W-1:0] * u_s7[i];
				phi_s8[i] <= fc_c[FC_W-1:LO_W] * u_s7[i];
			end
			kill_s8 <= kill_s7;
			neg_s8  <= neg_s7;
		end
	end

	// output: recombine, scale, saturate
	logic [2:0][P_W-1:0] pr_c, c_c;
	logic [2:0][31:0]    fo_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pr_c[i] = (P_W'(phi_s8[i]) << LO_W) + P_W'(plo_s8[i]);
			c_c[i]  = pr_c[i] >> FRAC_BITS;
			if (kill_s8) begin
				fo_c[i] = '0;
			end else if (neg_s8[i]) begin
				fo_c[i] = (|c_c[i][P_W-1:31]) ? 32'h8000_0000 : 32'(~c_c[i][31:0] + 32'd1);
			end else begin
				fo_c[i] = (|c_c[i][P_W-1:31]) ? 32'h7FFF_FFFF : c_c[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) m_tdata <= {fo_c[2], fo_c[1], fo_c[0]};
	end

endmodule

@@ design/safu_checker.sv @@
// Port-level checks on the sink attraction force unit, bound to the top level.
// Uses sink_attraction_force_unit_assert.svh.
`include "sink_attraction_force_unit_assert.svh"

module safu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	`SAFU_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`SAFU_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
	// input side keeps flowing whenever the output register can move
	`SAFU_ASSERT_SAME(a_ready_free, m_tready || !m_tvalid, s_tready)
	`SAFU_ASSERT_SAME(a_ready_stall, m_tvalid && !m_tready, !s_tready)
	`SAFU_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind sink_attraction_force_unit safu_checker u_safu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

@@ tb/sv/sink_attraction_force_unit_test.sv @@
// Self-checking testbench of sink_attraction_force_unit: directed and random particles
// against an internal force predictor, with random gaps and stalls on both streams.
// Depends on safu_pkg and the unit itself.
module sink_attraction_force_unit_test;
	import safu_pkg::*;

	localparam int FRAC_BITS  = 16;
	localparam int SETTLE     = 90;	// a little more than the pipeline latency
	localparam int IDLE_LIMIT = 5000;
	localparam logic [63:0] ALL_ONES64 = '1;

	typedef struct {
		logic [31:0] px, py, pz;
		logic [30:0] vol;
	} particle_t;

	typedef struct {
		logic [31:0] fx, fy, fz;
	} force_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [95:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = REG_SINK_X;
	logic [31:0] cfg_data = '0;

	sink_attraction_force_unit #(.FRAC_BITS(FRAC_BITS)) u_top (.*);

	always #5 clk = ~clk;

	// register copy, follows the cfg channel
	logic [31:0] sink_r [3];
	logic [30:0] peak_r, crit_r, drop_r;

	particle_t pending[$];
	force_t    forces_due[$];
	particle_t cur;
	int  gap_left = 0;
	int  stall_left = 0;
	logic rx_hold = 0;
	int  errors = 0;
	int  idle_cycles = 0;

	function automatic logic [33:0] root68(input logic [67:0] n);
		logic [127:0] r;
		logic [127:0] trial;
		r = '0;
		for (int i = 33; i >= 0; i--) begin
			trial = r | (128'd1 << i);
			if (trial * trial <= 128'(n))
				r = trial;
		end
		return r[33:0];
	endfunction

	function automatic logic [31:0] saturate(input logic neg, input logic [63:0] mag);
		if (neg)
			return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
		return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
	endfunction

	function automatic force_t predict_force(input particle_t p);
		logic [31:0] pos [3];
		logic signed [32:0] d;
		logic [32:0] ad [3];
		logic neg [3];
		logic [67:0] sum;
		logic [33:0] len;
		logic [127:0] prod, q;
		logic [30:0] crit;
		logic [63:0] f, u, c;
		logic [31:0] res [3];
		force_t out;
		pos[0] = p.px; pos[1] = p.py; pos[2] = p.pz;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			d = $signed({sink_r[i][31], sink_r[i]}) - $signed({pos[i][31], pos[i]});
			neg[i] = d[32];
			ad[i] = neg[i] ? 33'(-d) : 33'(d);
			sum += 68'(ad[i]) * 68'(ad[i]);
			res[i] = '0;
		end
		len = root68(sum);
		out.fx = '0; out.fy = '0; out.fz = '0;
		if (len == 0)
			return out;
		crit = (crit_r != 0) ? crit_r : 31'd1;
		prod = 128'(len) * 128'(drop_r);
		if (prod > 128'(ALL_ONES64))
			return out;
		q = prod / crit;
		if (q >= 128'(peak_r))
			return out;
		f = (64'(peak_r - q[30:0]) * 64'(p.vol)) >> FRAC_BITS;
		for (int i = 0; i < 3; i++) begin
			u = 64'((128'(ad[i]) << FRAC_BITS) / len);
			if (u == 0 || f == 0)
				c = '0;
			else begin
				prod = 128'(f) * 128'(u);
				c = (prod > 128'(ALL_ONES64)) ? ALL_ONES64 : 64'(prod >> FRAC_BITS);
			end
			res[i] = saturate(neg[i], c);
		end
		out.fx = res[0]; out.fy = res[1]; out.fz = res[2];
		return out;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h", field, got, want);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				forces_due.push_back(predict_force(cur));
			if (s_tvalid && !s_tready) begin
				next_valid = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				next_valid = 1'b0;
			end else if (pending.size() > 0) begin
				cur = pending.pop_front();
				s_tdata <= {1'b0, cur.vol, cur.pz, cur.py, cur.px};
				gap_left = pick_gap();
				next_valid = 1'b1;
			end else begin
				next_valid = 1'b0;
			end
			s_tvalid <= next_valid;
		end
	end

	// monitor and register tracking
	always @(posedge clk or negedge arst_n) begin
		force_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_r[0] = '0; sink_r[1] = '0; sink_r[2] = '0;
			peak_r = '0; crit_r = 31'd65536; drop_r = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SINK_X:    sink_r[0] = cfg_data;
					REG_SINK_Y:    sink_r[1] = cfg_data;
					REG_SINK_Z:    sink_r[2] = cfg_data;
					REG_PEAK:      peak_r = cfg_data[30:0];
					REG_CRIT_DIST: crit_r = cfg_data[30:0];
					REG_DROP:      drop_r = cfg_data[30:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (forces_due.size() == 0) begin
					report_mismatch("unexpected force_x", m_tdata[31:0], '0);
				end else begin
					want = forces_due.pop_front();
					if (m_tdata[31:0] !== want.fx)
						report_mismatch("force_x", m_tdata[31:0], want.fx);
					if (m_tdata[63:32] !== want.fy)
						report_mismatch("force_y", m_tdata[63:32], want.fy);
					if (m_tdata[95:64] !== want.fz)
						report_mismatch("force_z", m_tdata[95:64], want.fz);
				end
			end
			if (rx_hold) begin
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (arst_n && ++idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic add_particle(input logic [31:0] x, y, z, input logic [30:0] v);
		particle_t p;
		p.px = x; p.py = y; p.pz = z; p.vol = v;
		pending.push_back(p);
	endtask

	// sampled on the falling edge, when the driver's queue and valid have settled
	task automatic drain();
		while (pending.size() > 0 || s_tvalid || forces_due.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [31:0] sx, sy, sz, input logic [30:0] peak, crit,
			drop);
		write_reg(REG_SINK_X, sx);
		write_reg(REG_SINK_Y, sy);
		write_reg(REG_SINK_Z, sz);
		write_reg(REG_PEAK, {1'b0, peak});
		write_reg(REG_CRIT_DIST, {1'b0, crit});
		write_reg(REG_DROP, {1'b0, drop});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly near the sink so the force is not cut off, some anywhere
	task automatic random_particles(input int n, input int span);
		logic [31:0] p [3];
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 3; i++)
				p[i] = ($urandom_range(0, 3) == 0) ? $urandom()
					: sink_r[i] + 32'($urandom_range(0, 2 * span)) - 32'(span);
			add_particle(p[0], p[1], p[2],
				($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20)));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: peak is zero, so every force is zero
		add_particle(32'h0001_0000, 0, 0, 31'h0001_0000);
		add_particle(0, 0, 0, 31'h7FFF_FFFF);
		drain();

		configure(32'h03E8_0000, 32'hFC18_0000, 32'h0000_8000, 31'h000A_0000, 31'h0001_0000,
			31'h0001_0000);
		add_particle(32'h03E8_0000, 32'hFC18_0000, 32'h0000_8000, 31'h0001_0000); // on sink
		add_particle(32'h03E5_0000, 32'hFC18_0000, 32'h0000_8000, 31'h0001_0000);
		add_particle(32'h03E8_0000, 32'hFC1C_0000, 32'h0000_8000, 31'h0002_0000);
		add_particle(32'h03E8_0000, 32'hFC18_0000, 32'h0002_8000, 31'h0000_0000);
		add_particle(32'h03E9_0000, 32'hFC17_0000, 32'h0000_4000, 31'h7FFF_FFFF);
		add_particle(32'h03E8_0001, 32'hFC18_0000, 32'h0000_8000, 31'h0001_0000);
		add_particle(32'h03F8_0000, 32'hFC18_0000, 32'h0000_8000, 31'h0001_0000); // past range
		add_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0001_0000);
		drain();

		// no falloff, largest peak: saturation at the far corners
		configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'h0000_0000);
		add_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 31'h7FFF_FFFF);
		add_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 31'h7FFF_FFFF);
		add_particle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_0001);
		add_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 31'h7FFF_FFFF);
		add_particle(32'h8000_0001, 32'h7FFF_FFFF, 32'h0000_0000, 31'h0000_4000);
		drain();

		// largest drop with smallest distance scale: quotient overflow, cut-off or on the sink, zero force
		configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_0001,
			31'h7FFF_FFFF);
		add_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
		add_particle(32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
		drain();

		// back pressure: the receiver holds off while the sender keeps offering
		configure(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000, 31'h0100_0000, 31'h0004_0000,
			31'h0010_0000);
		rx_hold <= 1'b1;
		random_particles(150, 1 << 20);
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			configure($urandom(), $urandom(), $urandom(),
				(ph == 0) ? 31'h7FFF_FFFF : 31'($urandom_range(1, 1 << 28)),
				(ph == 1) ? 31'h7FFF_FFFF : 31'($urandom_range(1, 1 << 22)),
				(ph == 2) ? 31'd0 : 31'($urandom_range(0, 1 << 20)));
			random_particles(90, (ph % 2) ? (1 << 18) : (1 << 24));
			drain();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/safu_pkg.sv
design/sink_attraction_force_unit.sv
design/safu_checker.sv
tb/sv/sink_attraction_force_unit_test.sv
